>>> rtl/core/dsd_pkg.sv
// dsd_pkg: shared constants and types of the dominant stride detector
// no dependencies; imported by the cells, the vote stage and the top level

package dsd_pkg;

    localparam int STRIDE_W       = 32;
    localparam int WINDOW_DEFAULT = 8;

    // broadcast from the top level to every cell of the window
    typedef struct packed {
        logic                shift;     // a request is accepted this cycle
        logic [STRIDE_W-1:0] incoming;  // stride entering the window
        logic [STRIDE_W-1:0] oldest;    // stride leaving the window
    } cell_ctrl_t;

endpackage

>>> rtl/core/dsd_if.sv
// dsd_stride_if / dsd_result_if: valid/ready channels of the stride detector
// no dependencies

interface dsd_stride_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_stride;

    modport source (output valid, output new_stride, input ready);
    modport sink   (input valid, input new_stride, output ready);
endinterface

interface dsd_result_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [31:0] dominant_stride;

    modport source (output valid, output found, output dominant_stride, input ready);
    modport sink   (input valid, input found, input dominant_stride, output ready);
endinterface

>>> rtl/core/dominant_stride_detector_core.sv
// dominant_stride_detector_core: sliding-window majority vote on access strides
// depends on dsd_pkg, dsd_if, dsd_cell and dsd_vote

// One request carries one signed stride; one result follows for each, telling whether a
// single stride value fills more than WINDOW/2 of the last WINDOW strides and, if so,
// which. Strides are compared as raw 32-bit patterns. After reset the window holds
// WINDOW zero strides, so the first results report stride 0 as dominant. The window is
// a row of WINDOW cells; each keeps a stride and a running count of how many slots share
// its value, updated by one compare each against the entering and the leaving stride. A
// request is taken every cycle while the result side keeps up; the cells shift at the
// accepting edge, then the vote register loads once the output is free or being read.
// A stalled result holds the input off only once a second result is also waiting.

module dominant_stride_detector_core #(
    parameter int WINDOW = dsd_pkg::WINDOW_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    dsd_stride_if.sink    stride,
    dsd_result_if.source  result
);
    import dsd_pkg::*;

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int HALF  = WINDOW / 2;

    cell_ctrl_t          ctrl;
    logic                can_push;
    logic                push;
    logic [STRIDE_W-1:0] cell_val [WINDOW];
    logic [CNT_W-1:0]    cell_cnt [WINDOW];
    logic [CNT_W-1:0]    cell_upd [WINDOW];
    logic [WINDOW-1:0]   cell_match;
    logic [WINDOW-1:0]   cell_maj;
    logic [CNT_W-1:0]    match_cnt;
    logic [CNT_W-1:0]    entry_cnt;

    assign stride.ready  = can_push;
    assign push          = stride.valid && can_push;
    assign ctrl.shift    = push;
    assign ctrl.incoming = stride.new_stride;
    assign ctrl.oldest   = cell_val[WINDOW-1];

    // the new stride's count equals the updated count of any surviving slot that matches
    always_comb
    begin
        match_cnt = '0;
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            match_cnt = match_cnt | (cell_match[k] ? cell_upd[k] : '0);
        end
    end

    assign entry_cnt = (match_cnt == '0) ? CNT_W'(1) : match_cnt;

    for (genvar k = 0; k < WINDOW; k++)
    begin : g_cell
        dsd_cell #(
            .WINDOW (WINDOW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .in_val  ((k == 0) ? stride.new_stride : cell_val[(k == 0) ? 0 : k - 1]),
            .in_cnt  ((k == 0) ? entry_cnt : cell_upd[(k == 0) ? 0 : k - 1]),
            .val     (cell_val[k]),
            .cnt     (cell_cnt[k]),
            .cnt_upd (cell_upd[k]),
            .match   (cell_match[k]),
            .maj     (cell_maj[k])
        );
    end

    dsd_vote #(
        .WINDOW (WINDOW)
    ) u_vote (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_val (cell_val),
        .cell_maj (cell_maj),
        .push     (push),
        .can_push (can_push),
        .result   (result)
    );

`ifndef SYNTHESIS
    a_newest_slot: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> cell_val[0] == $past(stride.new_stride))
        else $error("dsd core: newest slot does not hold the accepted stride");

    a_maj_is_majority: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_maj) == 0 || $countones(cell_maj) > HALF)
        else $error("dsd core: majority flags set on too few slots");

    a_newest_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> cell_cnt[0] == $past(entry_cnt))
        else $error("dsd core: newest slot count mismatch");
`endif

endmodule

>>> rtl/core/dsd_cell.sv
// dsd_cell: one window slot, holding a stride and the number of slots that share its value
// depends on dsd_pkg

module dsd_cell #(
    parameter int   WINDOW = dsd_pkg::WINDOW_DEFAULT,
    localparam int  CNT_W  = $clog2(WINDOW + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dsd_pkg::cell_ctrl_t           ctrl,
    input  logic [dsd_pkg::STRIDE_W-1:0]  in_val,
    input  logic [CNT_W-1:0]              in_cnt,
    output logic [dsd_pkg::STRIDE_W-1:0]  val,
    output logic [CNT_W-1:0]              cnt,
    output logic [CNT_W-1:0]              cnt_upd,
    output logic                          match,
    output logic                          maj
);
    import dsd_pkg::*;

    localparam int HALF = WINDOW / 2;

    logic [STRIDE_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                maj_reg, maj_next;
    logic                eq_old;
    logic [CNT_W:0]      cnt_sum;

    assign match  = (val_reg == ctrl.incoming);
    assign eq_old = (val_reg == ctrl.oldest);

    // count of this value in the window after the push
    assign cnt_sum = {1'b0, cnt_reg} + (CNT_W + 1)'(match) - (CNT_W + 1)'(eq_old);
    assign cnt_upd = cnt_sum[CNT_W-1:0];

    always_comb
    begin
        val_next = val_reg;
        cnt_next = cnt_reg;
        maj_next = maj_reg;
        if (ctrl.shift)
        begin
            val_next = in_val;
            cnt_next = in_cnt;
            maj_next = (in_cnt > CNT_W'(HALF));
        end
    end

    // after reset every slot holds zero, so each count is the full window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            cnt_reg <= CNT_W'(WINDOW);
            maj_reg <= 1'b1;
        end
        else
        begin
            val_reg <= val_next;
            cnt_reg <= cnt_next;
            maj_reg <= maj_next;
        end
    end

    assign val = val_reg;
    assign cnt = cnt_reg;
    assign maj = maj_reg;

`ifndef SYNTHESIS
    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0)
        else $error("dsd_cell: slot count is zero");

    a_maj_tracks_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |=> maj_reg == (cnt_reg > CNT_W'(HALF)))
        else $error("dsd_cell: majority flag out of step with count");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.shift |=> $stable(val_reg) && $stable(cnt_reg))
        else $error("dsd_cell: slot changed without a request");
`endif

endmodule

>>> rtl/core/dsd_vote.sv
// dsd_vote: picks the majority stride from the cell flags and holds the result register
// depends on dsd_pkg and dsd_if

module dsd_vote #(
    parameter int WINDOW = dsd_pkg::WINDOW_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [dsd_pkg::STRIDE_W-1:0]  cell_val [WINDOW],
    input  logic [WINDOW-1:0]             cell_maj,
    input  logic                          push,
    output logic                          can_push,
    dsd_result_if.source                  result
);
    import dsd_pkg::*;

    logic                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    logic                found_reg, found_next;
    logic [STRIDE_W-1:0] dom_reg, dom_next;
    logic                load;
    logic [STRIDE_W-1:0] dom_sel;

    // every flagged slot holds the same value, so an or-reduce selects it
    always_comb
    begin
        dom_sel = '0;
        for (int k = 0; k < WINDOW; k++)
        begin
            dom_sel = dom_sel | (cell_maj[k] ? cell_val[k] : '0);
        end
    end

    assign load     = pend_reg && (!out_valid_reg || result.ready);
    assign can_push = !pend_reg || load;

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        dom_next       = dom_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            found_next     = |cell_maj;
            dom_next       = dom_sel;
            pend_next      = 1'b0;
        end
        if (push)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        dom_reg   <= dom_next;
    end

    assign result.valid           = out_valid_reg;
    assign result.found           = found_reg;
    assign result.dominant_stride = dom_reg;

`ifndef SYNTHESIS
    a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !load && !push |=> pend_reg)
        else $error("dsd_vote: pending request dropped");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result.valid)
        else $error("dsd_vote: loaded result not presented");

    a_zero_when_none: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |-> result.dominant_stride == '0)
        else $error("dsd_vote: stride nonzero without a majority");
`endif

endmodule

>>> tb/tb_dominant_stride_detector_core.sv
// tb_dominant_stride_detector_core: self-checking bench for the stride majority detector
// depends on dsd_pkg, dsd_if and the dominant_stride_detector_core rtl

module tb_dominant_stride_detector_core;

    import dsd_pkg::*;

    localparam int WIN          = WINDOW_DEFAULT;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 340;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic                found;
        logic [STRIDE_W-1:0] stride;
    } vote_t;

    logic clk = 1'b0;
    logic rst_n;

    dsd_stride_if stride_ch ();
    dsd_result_if result_ch ();

    dominant_stride_detector_core #(
        .WINDOW (WIN)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stride (stride_ch),
        .result (result_ch)
    );

    always #1 clk = ~clk;

    // bench copy of the window, entry 0 newest
    logic [STRIDE_W-1:0] stride_hist [WIN];
    vote_t               pending_votes [$];

    int errors         = 0;
    int strides_sent   = 0;
    int votes_checked  = 0;
    int majorities     = 0;
    int input_stalls   = 0;
    bit src_idle_en    = 1'b1;
    bit sink_idle_en   = 1'b1;
    int hold_left      = 0;

    function automatic vote_t predict_vote(input logic [STRIDE_W-1:0] s);
        vote_t v;
        int    n;
        v = '0;
        for (int k = WIN - 1; k > 0; k--)
            stride_hist[k] = stride_hist[k-1];
        stride_hist[0] = s;
        for (int k = 0; k < WIN; k++) begin
            n = 0;
            for (int j = 0; j < WIN; j++)
                if (stride_hist[j] == stride_hist[k])
                    n++;
            if (n > WIN / 2 && !v.found) begin
                v.found  = 1'b1;
                v.stride = stride_hist[k];
            end
        end
        return v;
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endtask

    // one checking process for both channels
    always @(posedge clk) begin : scoreboard
        vote_t want;
        if (rst_n === 1'b1) begin
            if (result_ch.valid && result_ch.ready) begin
                votes_checked++;
                if (pending_votes.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result found=%0b stride=%h",
                                            result_ch.found, result_ch.dominant_stride));
                end else begin
                    want = pending_votes.pop_front();
                    if (want.found) majorities++;
                    if (result_ch.found !== want.found ||
                        result_ch.dominant_stride !== want.stride)
                        flag_mismatch($sformatf(
                            "result %0d: expected found=%0b stride=%h, got found=%0b stride=%h",
                            votes_checked, want.found, want.stride,
                            result_ch.found, result_ch.dominant_stride));
                end
            end
            if (stride_ch.valid && stride_ch.ready) begin
                pending_votes.push_back(predict_vote(stride_ch.new_stride));
                strides_sent++;
            end else if (stride_ch.valid) begin
                input_stalls++;
            end
        end
    end

    // result side: random stall bursts, plus a long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_left != 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 8) - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_stride(input logic [STRIDE_W-1:0] s);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            stride_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stride_ch.valid      <= 1'b1;
        stride_ch.new_stride <= s;
        @(posedge clk);
        while (!stride_ch.ready) @(posedge clk);
    endtask

    task automatic send_run(input logic [STRIDE_W-1:0] s, input int n);
        for (int i = 0; i < n; i++)
            send_stride(s);
    endtask

    // zero window after reset votes for stride 0 until enough new strides arrive
    task automatic test_reset_window();
        send_run(32'd7, 5);
    endtask

    // sign extremes, exact half split (no majority) and all-ones pattern
    task automatic test_extremes();
        send_run(32'h8000_0000, 5);
        send_run(32'h7fff_ffff, 4);
        send_run(32'hffff_ffff, 5);
        send_stride(32'h0000_0001);
        send_stride(32'hffff_fffe);
        send_run(32'h0000_0000, 3);
    endtask

    task automatic test_random_strides(input int count);
        int                  sent;
        int                  mode;
        int                  len;
        logic [STRIDE_W-1:0] dom;
        logic [STRIDE_W-1:0] pool [3];
        sent = 0;
        while (sent < count) begin
            mode = $urandom_range(0, 9);
            if (mode < 4) begin
                // a stride that dominates, broken up by noise
                dom = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 64) - 32;
                len = $urandom_range(6, 16);
                for (int i = 0; i < len; i++)
                    send_stride(($urandom_range(0, 9) < 7) ? dom : $urandom);
            end else if (mode < 7) begin
                // few distinct values, majorities come and go
                for (int i = 0; i < 3; i++)
                    pool[i] = $urandom;
                len = 8;
                for (int i = 0; i < len; i++)
                    send_stride(pool[$urandom_range(0, 2)]);
            end else begin
                len = $urandom_range(4, 8);
                for (int i = 0; i < len; i++)
                    send_stride($urandom);
            end
            sent += len;
        end
    endtask

    // receiver holds off long enough for the block to fill and stall the input
    task automatic test_backpressure();
        logic [STRIDE_W-1:0] dom;
        dom = $urandom;
        src_idle_en = 1'b0;
        hold_left   = 40;
        for (int i = 0; i < 24; i++)
            send_stride(($urandom_range(0, 3) != 0) ? dom : $urandom);
        src_idle_en = 1'b1;
    endtask

    task automatic test_full_rate();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_strides(60);
    endtask

    initial begin : timeout
        #(2 * LIMIT_CYCLES);
        $display("tb_dominant_stride_detector_core failed");
        $finish;
    end

    initial begin : main
        for (int k = 0; k < WIN; k++)
            stride_hist[k] = '0;
        rst_n                <= 1'b0;
        stride_ch.valid      <= 1'b0;
        stride_ch.new_stride <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_extremes();
        test_random_strides(RANDOM_ITEMS / 2);
        test_backpressure();
        test_random_strides(RANDOM_ITEMS / 2);
        test_full_rate();
        stride_ch.valid <= 1'b0;

        while (pending_votes.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("run covered %0d strides and %0d results, %0d with a majority stride",
                 strides_sent, votes_checked, majorities);
        $display("input was held off for %0d cycles, %0d errors", input_stalls, errors);
        if (errors == 0)
            $display("tb_dominant_stride_detector_core passed");
        else
            $display("tb_dominant_stride_detector_core failed");
        $finish;
    end

endmodule

>>> dominant_stride_detector_core.f
rtl/core/dsd_pkg.sv
rtl/core/dsd_if.sv
rtl/core/dsd_cell.sv
rtl/core/dsd_vote.sv
rtl/core/dominant_stride_detector_core.sv
tb/tb_dominant_stride_detector_core.sv
